// ===== rtl/core/color_palette_and_bank_select_port_defines.svh =====
// Assertion macros for the colour palette and bank select port
`ifndef COLOR_PALETTE_AND_BANK_SELECT_PORT_DEFINES_SVH
`define COLOR_PALETTE_AND_BANK_SELECT_PORT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CPB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cpb_pkg.sv =====
// Shared types and constants for the colour palette and bank select port
package cpb_pkg;

  localparam int PAL_BYTES = 64;
  localparam int PAL_AW    = $clog2(PAL_BYTES);
  localparam int IDX_W     = 6;

  localparam logic [15:0] ADDR_VBK  = 16'hFF4F;
  localparam logic [15:0] ADDR_BCPS = 16'hFF68;
  localparam logic [15:0] ADDR_BCPD = 16'hFF69;
  localparam logic [15:0] ADDR_OCPS = 16'hFF6A;
  localparam logic [15:0] ADDR_OCPD = 16'hFF6B;
  localparam logic [15:0] ADDR_SVBK = 16'hFF70;

  localparam logic [7:0] BG_FILL  = 8'hFF;
  localparam logic [7:0] OBJ_FILL = 8'h00;

  typedef enum logic [2:0] {
    RGN_NONE = 3'd0,
    RGN_REG  = 3'd1,
    RGN_PAL  = 3'd2,
    RGN_VRAM = 3'd3,
    RGN_WRAM = 3'd4
  } region_t;

  typedef enum logic [3:0] {
    TGT_NONE,
    TGT_BCPS,
    TGT_OCPS,
    TGT_VBK,
    TGT_SVBK,
    TGT_BCPD,
    TGT_OCPD,
    TGT_VRAM,
    TGT_WRAM0,
    TGT_WRAMX
  } target_t;

  typedef struct packed {
    target_t     target;
    region_t     region;
    logic [12:0] offset;
  } dec_t;

  typedef struct packed {
    logic       rd_en;
    logic       idx_we;
    logic       data_we;
    logic [7:0] wdata;
  } pal_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

// ===== rtl/core/cpb_ram.sv =====
// Generic single-port-write, registered-read RAM
module cpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cpb_decode.sv =====
// Address decoder: target register or window, region code and bank offset
module cpb_decode (
  input  logic [15:0]   address,
  output cpb_pkg::dec_t dec
);

  always_comb begin
    dec.target = cpb_pkg::TGT_NONE;
    dec.region = cpb_pkg::RGN_NONE;
    dec.offset = 13'd0;
    if (address[15:13] == 3'b100) begin
      dec.target = cpb_pkg::TGT_VRAM;
      dec.region = cpb_pkg::RGN_VRAM;
      dec.offset = address[12:0];
    end else if (address[15:12] == 4'hC) begin
      dec.target = cpb_pkg::TGT_WRAM0;
      dec.region = cpb_pkg::RGN_WRAM;
      dec.offset = {1'b0, address[11:0]};
    end else if (address[15:12] == 4'hD) begin
      dec.target = cpb_pkg::TGT_WRAMX;
      dec.region = cpb_pkg::RGN_WRAM;
      dec.offset = {1'b0, address[11:0]};
    end else if (address == cpb_pkg::ADDR_BCPS) begin
      dec.target = cpb_pkg::TGT_BCPS;
      dec.region = cpb_pkg::RGN_REG;
    end else if (address == cpb_pkg::ADDR_OCPS) begin
      dec.target = cpb_pkg::TGT_OCPS;
      dec.region = cpb_pkg::RGN_REG;
    end else if (address == cpb_pkg::ADDR_VBK) begin
      dec.target = cpb_pkg::TGT_VBK;
      dec.region = cpb_pkg::RGN_REG;
    end else if (address == cpb_pkg::ADDR_SVBK) begin
      dec.target = cpb_pkg::TGT_SVBK;
      dec.region = cpb_pkg::RGN_REG;
    end else if (address == cpb_pkg::ADDR_BCPD) begin
      dec.target = cpb_pkg::TGT_BCPD;
      dec.region = cpb_pkg::RGN_PAL;
    end else if (address == cpb_pkg::ADDR_OCPD) begin
      dec.target = cpb_pkg::TGT_OCPD;
      dec.region = cpb_pkg::RGN_PAL;
    end
  end

endmodule

// ===== rtl/core/cpb_palette.sv =====
// One palette: index register, entry valid bits and the palette RAM
module cpb_palette (
  input  logic                         clk,
  input  logic                         rst,
  input  cpb_pkg::pal_ctrl_t           ctrl,
  output logic                         auto_inc,
  output logic [cpb_pkg::IDX_W-1:0]    idx,
  output logic                         hit,
  output logic [7:0]                   rdata
);

  logic [cpb_pkg::PAL_BYTES-1:0] valid;
  logic [cpb_pkg::PAL_AW-1:0]    addr;

  assign addr = idx[cpb_pkg::PAL_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_inc <= 1'b0;
      idx      <= '0;
      valid    <= '0;
      hit      <= 1'b0;
    end else begin
      if (ctrl.rd_en) begin
        hit <= valid[addr];
      end
      if (ctrl.idx_we) begin
        auto_inc <= ctrl.wdata[7];
        idx      <= cpb_pkg::IDX_W'(ctrl.wdata[5:0] % cpb_pkg::PAL_BYTES);
      end else if (ctrl.data_we) begin
        valid[addr] <= 1'b1;
        // advance and wrap at the palette size
        if (auto_inc) begin
          idx <= cpb_pkg::IDX_W'(({1'b0, idx} + 7'd1) % cpb_pkg::PAL_BYTES);
        end
      end
    end
  end

  cpb_ram #(
    .WIDTH(8),
    .DEPTH(cpb_pkg::PAL_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.data_we),
    .waddr(addr),
    .wdata(ctrl.wdata),
    .re   (ctrl.rd_en),
    .raddr(addr),
    .rdata(rdata)
  );

endmodule

// ===== rtl/core/color_palette_and_bank_select_port.sv =====
// An accepted beat is held in the ST_LOOK state and its result is registered into the
// output register once that is free; a new beat is taken only back in ST_IDLE.
// A finished result waits in the output register while the next beat is taken.
// Reset: index registers, bank selects and colour mode clear at once; palette
// entries carry valid bits, so unwritten entries read as 0xFF (background) or
// 0x00 (objects) with no clearing pass.
`include "color_palette_and_bank_select_port_defines.svh"

module color_palette_and_bank_select_port (
  input  logic        clk,
  input  logic        rst,
  // configuration: colour mode
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  // input access
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
  input  logic        s_tuser,   // command (0 read, 1 write)
  // result
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] read_data, [10:8] bank, [23:11] offset
  output logic [2:0]  m_tuser    // region
);

  cpb_pkg::state_t    state, state_next;
  cpb_pkg::dec_t      dec;
  cpb_pkg::pal_ctrl_t bg_ctrl, obj_ctrl;

  logic        color_mode;
  logic        vbk;
  logic [2:0]  svbk;
  logic        cmd;
  logic [15:0] addr;
  logic [7:0]  wdata;

  logic        accept, commit, out_free;
  logic        bg_auto, obj_auto, bg_hit, obj_hit;
  logic [5:0]  bg_idx, obj_idx;
  logic [7:0]  bg_rdata, obj_rdata;
  logic [7:0]  rd_res;
  logic [2:0]  bank_res;
  logic [12:0] off_res;

  // refuse beats while reset is held
  assign cfg_ready = !rst;
  assign out_free  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cpb_pkg::ST_IDLE: if (accept) state_next = cpb_pkg::ST_LOOK;
      cpb_pkg::ST_LOOK: if (out_free) state_next = cpb_pkg::ST_IDLE;
      default:          state_next = cpb_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    commit   = 1'b0;
    case (state)
      cpb_pkg::ST_IDLE: s_tready = !rst;
      cpb_pkg::ST_LOOK: commit   = out_free;
      default: begin
        s_tready = 1'b0;
        commit   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= s_tuser;
      addr  <= s_tdata[15:0];
      wdata <= s_tdata[23:16];
    end
  end

  cpb_decode u_decode (
    .address(addr),
    .dec    (dec)
  );

  // both palettes are read at every accept; the decode picks one later
  always_comb begin
    bg_ctrl.rd_en    = accept;
    bg_ctrl.idx_we   = commit && cmd && (dec.target == cpb_pkg::TGT_BCPS);
    bg_ctrl.data_we  = commit && cmd && (dec.target == cpb_pkg::TGT_BCPD);
    bg_ctrl.wdata    = wdata;
    obj_ctrl.rd_en   = accept;
    obj_ctrl.idx_we  = commit && cmd && (dec.target == cpb_pkg::TGT_OCPS);
    obj_ctrl.data_we = commit && cmd && (dec.target == cpb_pkg::TGT_OCPD);
    obj_ctrl.wdata   = wdata;
  end

  cpb_palette u_bg (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (bg_ctrl),
    .auto_inc(bg_auto),
    .idx     (bg_idx),
    .hit     (bg_hit),
    .rdata   (bg_rdata)
  );

  cpb_palette u_obj (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (obj_ctrl),
    .auto_inc(obj_auto),
    .idx     (obj_idx),
    .hit     (obj_hit),
    .rdata   (obj_rdata)
  );

  // colour mode and bank selects
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= 1'b0;
      vbk        <= 1'b0;
      svbk       <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        color_mode <= cfg_data;
      end
      if (commit && cmd && color_mode && (dec.target == cpb_pkg::TGT_VBK)) begin
        vbk <= wdata[0];
      end
      if (commit && cmd && color_mode && (dec.target == cpb_pkg::TGT_SVBK)) begin
        svbk <= wdata[2:0];
      end
    end
  end

  // result fields
  always_comb begin
    rd_res   = 8'd0;
    bank_res = 3'd0;
    off_res  = dec.offset;
    case (dec.target)
      cpb_pkg::TGT_BCPS:  rd_res = {bg_auto, 1'b1, bg_idx};
      cpb_pkg::TGT_OCPS:  rd_res = {obj_auto, 1'b1, obj_idx};
      cpb_pkg::TGT_VBK:   rd_res = {7'h7F, vbk};
      cpb_pkg::TGT_SVBK:  rd_res = {5'h1F, svbk};
      cpb_pkg::TGT_BCPD:  rd_res = bg_hit ? bg_rdata : cpb_pkg::BG_FILL;
      cpb_pkg::TGT_OCPD:  rd_res = obj_hit ? obj_rdata : cpb_pkg::OBJ_FILL;
      cpb_pkg::TGT_VRAM:  bank_res = {2'b00, color_mode & vbk};
      cpb_pkg::TGT_WRAM0: bank_res = 3'd0;
      // select 0 maps to bank 1
      cpb_pkg::TGT_WRAMX: bank_res = (color_mode && svbk != 3'd0) ? svbk : 3'd1;
      default:            rd_res = 8'd0;
    endcase
    if (cmd) begin
      rd_res = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {off_res, bank_res, rd_res};
      m_tuser <= dec.region;
    end
  end

  `CPB_ASSERT_NEXT(a_accept_look, accept, state == cpb_pkg::ST_LOOK,
                   "accepted beat did not move to lookup")
  `CPB_ASSERT_NEXT(a_commit_valid, commit, m_tvalid,
                   "committed result not presented")
  `CPB_ASSERT_NOW(a_no_bank_outside_ram,
                  m_tvalid && (m_tuser == cpb_pkg::RGN_NONE || m_tuser == cpb_pkg::RGN_REG ||
                               m_tuser == cpb_pkg::RGN_PAL),
                  m_tdata[23:8] == 16'd0,
                  "bank or offset set outside a RAM window")

endmodule

// ===== bench/color_palette_and_bank_select_port_test.sv =====
// Self-checking bench for the colour palette and bank select port: bus accesses in, results out
module color_palette_and_bank_select_port_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] VRAM_LO  = 16'h8000;
  localparam logic [15:0] VRAM_HI  = 16'h9FFF;
  localparam logic [15:0] WRAM0_LO = 16'hC000;
  localparam logic [15:0] WRAMX_LO = 16'hD000;
  localparam logic [15:0] WRAM_HI  = 16'hDFFF;
  localparam int TOTAL_ACCESSES    = 1850;
  localparam int HOLD_OFF_CYCLES   = 250;
  localparam int CYCLE_LIMIT       = 400000;

  typedef enum bit {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } access_cmd_t;

  typedef struct {
    logic [7:0]       read_data;
    cpb_pkg::region_t region;
    logic [2:0]       bank;
    logic [12:0]      offset;
  } access_result_t;

  // Tracks palette, index and bank-select state and holds the results still owed
  class palette_bank_scoreboard;
    bit             color_mode;
    logic [7:0]     bg_pal  [cpb_pkg::PAL_BYTES];
    logic [7:0]     obj_pal [cpb_pkg::PAL_BYTES];
    bit             bg_auto;
    bit             obj_auto;
    int             bg_idx;
    int             obj_idx;
    bit             vram_sel;
    logic [2:0]     wram_sel;
    access_result_t pending_results[$];
    int             mismatches;
    int             results_checked;

    function new();
      color_mode = 1'b0;
      foreach (bg_pal[i]) bg_pal[i] = cpb_pkg::BG_FILL;
      foreach (obj_pal[i]) obj_pal[i] = cpb_pkg::OBJ_FILL;
      bg_auto = 1'b0;
      obj_auto = 1'b0;
      bg_idx = 0;
      obj_idx = 0;
      vram_sel = 1'b0;
      wram_sel = 3'd0;
      mismatches = 0;
      results_checked = 0;
    endfunction

    function void note_color_mode(bit mode);
      color_mode = mode;
    endfunction

    function void note_access(access_cmd_t cmd, logic [15:0] addr, logic [7:0] wdata);
      access_result_t r;
      bit wr;
      wr = (cmd == CMD_WRITE);
      r.read_data = 8'h00;
      r.region = cpb_pkg::RGN_NONE;
      r.bank = 3'd0;
      r.offset = 13'd0;
      if (addr >= VRAM_LO && addr <= VRAM_HI) begin
        r.region = cpb_pkg::RGN_VRAM;
        r.bank = color_mode ? {2'b00, vram_sel} : 3'd0;
        r.offset = 13'(addr - VRAM_LO);
      end else if (addr >= WRAM0_LO && addr < WRAMX_LO) begin
        r.region = cpb_pkg::RGN_WRAM;
        r.offset = 13'(addr - WRAM0_LO);
      end else if (addr >= WRAMX_LO && addr <= WRAM_HI) begin
        r.region = cpb_pkg::RGN_WRAM;
        // a select of zero still maps the switchable window to bank one
        r.bank = (color_mode && wram_sel != 3'd0) ? wram_sel : 3'd1;
        r.offset = 13'(addr - WRAMX_LO);
      end else if (addr == cpb_pkg::ADDR_BCPS) begin
        r.region = cpb_pkg::RGN_REG;
        if (wr) begin
          bg_auto = wdata[7];
          bg_idx = wdata[5:0] % cpb_pkg::PAL_BYTES;
        end else begin
          r.read_data = {bg_auto, 1'b1, 6'(bg_idx)};
        end
      end else if (addr == cpb_pkg::ADDR_OCPS) begin
        r.region = cpb_pkg::RGN_REG;
        if (wr) begin
          obj_auto = wdata[7];
          obj_idx = wdata[5:0] % cpb_pkg::PAL_BYTES;
        end else begin
          r.read_data = {obj_auto, 1'b1, 6'(obj_idx)};
        end
      end else if (addr == cpb_pkg::ADDR_VBK) begin
        r.region = cpb_pkg::RGN_REG;
        if (wr) begin
          if (color_mode) vram_sel = wdata[0];
        end else begin
          r.read_data = {7'h7F, vram_sel};
        end
      end else if (addr == cpb_pkg::ADDR_SVBK) begin
        r.region = cpb_pkg::RGN_REG;
        if (wr) begin
          if (color_mode) wram_sel = wdata[2:0];
        end else begin
          r.read_data = {5'h1F, wram_sel};
        end
      end else if (addr == cpb_pkg::ADDR_BCPD) begin
        r.region = cpb_pkg::RGN_PAL;
        if (wr) begin
          bg_pal[bg_idx] = wdata;
          if (bg_auto) bg_idx = (bg_idx + 1) % cpb_pkg::PAL_BYTES;
        end else begin
          r.read_data = bg_pal[bg_idx];
        end
      end else if (addr == cpb_pkg::ADDR_OCPD) begin
        r.region = cpb_pkg::RGN_PAL;
        if (wr) begin
          obj_pal[obj_idx] = wdata;
          if (obj_auto) obj_idx = (obj_idx + 1) % cpb_pkg::PAL_BYTES;
        end else begin
          r.read_data = obj_pal[obj_idx];
        end
      end
      pending_results.insert(pending_results.size(), r);
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t ns: result %0d mismatch: %s", $time, results_checked, what);
    endtask

    task check_result(logic [7:0] rd, cpb_pkg::region_t rgn, logic [2:0] bnk,
                      logic [12:0] ofs);
      access_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result beat, region %0d", rgn));
        return;
      end
      e = pending_results.pop_front();
      results_checked++;
      if (rd !== e.read_data)
        report($sformatf("read_data %h, want %h", rd, e.read_data));
      if (rgn !== e.region)
        report($sformatf("region %0d, want %0d", rgn, e.region));
      if (bnk !== e.bank)
        report($sformatf("bank %0d, want %0d", bnk, e.bank));
      if (ofs !== e.offset)
        report($sformatf("offset %h, want %h", ofs, e.offset));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [15:0] address, [23:16] write_data
  logic        s_tuser = 1'b0; // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [7:0] read_data, [10:8] bank, [23:11] offset
  logic [2:0]  m_tuser;        // region

  palette_bank_scoreboard sb;
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  int items_sent   = 0;
  int mode_writes  = 0;
  int cycle_count  = 0;

  color_palette_and_bank_select_port u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // watch every handshake and keep the scoreboard in step
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.note_color_mode(cfg_data);
      if (s_tvalid && s_tready)
        sb.note_access(access_cmd_t'(s_tuser), s_tdata[15:0], s_tdata[23:16]);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata[7:0], cpb_pkg::region_t'(m_tuser), m_tdata[10:8],
                        m_tdata[23:11]);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(99) < 25) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_access(input access_cmd_t cmd, input logic [15:0] addr,
                             input logic [7:0] wdata);
    int gap;
    if (src_idle_on && $urandom_range(99) < 25) begin
      gap = $urandom_range(3, 1);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {wdata, addr};
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_color_mode(input bit mode);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  function automatic logic [15:0] pick_address();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return cpb_pkg::ADDR_BCPD;
    if (sel < 20) return cpb_pkg::ADDR_OCPD;
    if (sel < 25) return cpb_pkg::ADDR_BCPS;
    if (sel < 30) return cpb_pkg::ADDR_OCPS;
    if (sel < 35) return cpb_pkg::ADDR_VBK;
    if (sel < 40) return cpb_pkg::ADDR_SVBK;
    if (sel < 55) return 16'($urandom_range(VRAM_HI, VRAM_LO));
    if (sel < 70) return 16'($urandom_range(WRAM_HI, WRAM0_LO));
    // the register page around the claimed addresses
    if (sel < 80) return 16'($urandom_range(16'hFF7F, 16'hFF40));
    return 16'($urandom);
  endfunction

  task automatic run_random(input int count);
    int          stop_at;
    int          kind;
    int          len;
    int          k;
    int          start;
    bit          use_obj;
    bit          autoinc;
    logic [15:0] idx_addr;
    logic [15:0] dat_addr;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        // palette burst: set index, stream bytes, then read each one back
        use_obj = $urandom_range(1);
        idx_addr = use_obj ? cpb_pkg::ADDR_OCPS : cpb_pkg::ADDR_BCPS;
        dat_addr = use_obj ? cpb_pkg::ADDR_OCPD : cpb_pkg::ADDR_BCPD;
        autoinc = ($urandom_range(9) != 0);
        start = $urandom_range(cpb_pkg::PAL_BYTES - 1);
        len = $urandom_range(10, 1);
        send_access(CMD_WRITE, idx_addr, {autoinc, 1'($urandom_range(1)), 6'(start)});
        for (k = 0; k < len; k++)
          send_access(CMD_WRITE, dat_addr, 8'($urandom_range(255)));
        for (k = 0; k < len; k++) begin
          send_access(CMD_WRITE, idx_addr,
                      {1'($urandom_range(1)), 1'($urandom_range(1)),
                       6'((start + k) % cpb_pkg::PAL_BYTES)});
          send_access(CMD_READ, dat_addr, 8'($urandom_range(255)));
          if ($urandom_range(3) == 0) send_access(CMD_READ, idx_addr, 8'h00);
        end
      end else if (kind < 50) begin
        // bank switch followed by RAM accesses through it
        if ($urandom_range(1))
          send_access(CMD_WRITE, cpb_pkg::ADDR_VBK, 8'($urandom_range(255)));
        else
          send_access(CMD_WRITE, cpb_pkg::ADDR_SVBK, 8'($urandom_range(255)));
        len = $urandom_range(3, 1);
        for (k = 0; k < len; k++)
          send_access(access_cmd_t'($urandom_range(1)),
                      $urandom_range(1) ? 16'($urandom_range(VRAM_HI, VRAM_LO))
                                        : 16'($urandom_range(WRAM_HI, WRAMX_LO)),
                      8'($urandom_range(255)));
        send_access(CMD_READ, $urandom_range(1) ? cpb_pkg::ADDR_VBK : cpb_pkg::ADDR_SVBK,
                    8'h00);
      end else begin
        send_access(access_cmd_t'($urandom_range(1)), pick_address(),
                    8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values and the fixed bits of every register
    send_access(CMD_READ, cpb_pkg::ADDR_VBK, 8'h00);
    send_access(CMD_READ, cpb_pkg::ADDR_SVBK, 8'h00);
    send_access(CMD_READ, cpb_pkg::ADDR_BCPS, 8'h00);
    send_access(CMD_READ, cpb_pkg::ADDR_OCPS, 8'h00);
    send_access(CMD_READ, cpb_pkg::ADDR_BCPD, 8'h00);
    send_access(CMD_READ, cpb_pkg::ADDR_OCPD, 8'h00);
    // bank selects hold outside colour mode; RAM maps to banks 0 and 1
    send_access(CMD_WRITE, cpb_pkg::ADDR_VBK, 8'hFF);
    send_access(CMD_WRITE, cpb_pkg::ADDR_SVBK, 8'hFF);
    send_access(CMD_READ, cpb_pkg::ADDR_SVBK, 8'h00);
    send_access(CMD_READ, VRAM_HI, 8'h00);
    send_access(CMD_WRITE, WRAM0_LO, 8'hFF);
    send_access(CMD_READ, WRAM_HI, 8'h00);
    send_access(CMD_WRITE, 16'hFFFF, 8'hFF);
    send_access(CMD_READ, 16'h0000, 8'h00);
    send_access(CMD_READ, 16'hE000, 8'h00);
    // auto-increment wraps past the top entry; bit 6 of an index write is dropped
    send_access(CMD_WRITE, cpb_pkg::ADDR_BCPS, 8'hFF);
    send_access(CMD_WRITE, cpb_pkg::ADDR_BCPD, 8'hA5);
    send_access(CMD_READ, cpb_pkg::ADDR_BCPS, 8'h00);
    send_access(CMD_READ, cpb_pkg::ADDR_BCPD, 8'h00);
    send_access(CMD_WRITE, cpb_pkg::ADDR_OCPS, 8'h3F);
    send_access(CMD_WRITE, cpb_pkg::ADDR_OCPD, 8'h5A);
    send_access(CMD_READ, cpb_pkg::ADDR_OCPD, 8'h00);

    set_color_mode(1'b1);
    // work-RAM select of zero still gives bank one
    send_access(CMD_WRITE, cpb_pkg::ADDR_SVBK, 8'hF8);
    send_access(CMD_READ, WRAMX_LO, 8'h00);
    send_access(CMD_WRITE, cpb_pkg::ADDR_SVBK, 8'h07);
    send_access(CMD_READ, WRAMX_LO, 8'h00);
    send_access(CMD_WRITE, cpb_pkg::ADDR_VBK, 8'h01);
    send_access(CMD_READ, VRAM_LO, 8'h00);
    send_access(CMD_READ, cpb_pkg::ADDR_VBK, 8'h00);

    run_random(450);
    set_color_mode(1'b0);
    // sender keeps offering while the receiver holds off; no idling for a while
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    hold_off_req = 1'b1;
    run_random(350);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    set_color_mode(1'b1);
    run_random(300);
    drain_results();
    run_random(300);
    set_color_mode(1'b0);
    run_random(200);
    set_color_mode(1'b1);
    if (items_sent < TOTAL_ACCESSES) run_random(TOTAL_ACCESSES - items_sent);

    drain_results();
    repeat (8) @(posedge clk);
    $display("Run covered %0d bus accesses and %0d checked results across %0d mode writes:",
             items_sent, sb.results_checked, mode_writes);
    $display("  palette bursts with index wrap, bank switching in both modes, unclaimed space.");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cpb_pkg.sv
rtl/core/cpb_ram.sv
rtl/core/cpb_decode.sv
rtl/core/cpb_palette.sv
rtl/core/color_palette_and_bank_select_port.sv
bench/color_palette_and_bank_select_port_test.sv
